@@ hw/rtl/wrms_pkg.sv @@
// wrms_pkg: shared types and constants of the windowed rms block
// no dependencies; used by windowed_rms and its testbench
`default_nettype none

package wrms_pkg;

  localparam int IN_W  = 16;  // width of the sample port
  localparam int CFG_W = 11;  // width of the window length register
  localparam int RMS_W = 16;  // width of the result port

  localparam int SAMPLE_RATE_HZ = 1600;
  localparam int LINE_FREQ_HZ   = 50;
  localparam int WINDOW_RESET   = SAMPLE_RATE_HZ / LINE_FREQ_HZ;

  localparam logic [RMS_W-1:0] RMS_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } wrms_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/wrms_sub.sv @@
// wrms_sub: shared compare and subtract unit for the divider and square root steps
// no dependencies; instantiated by windowed_rms
`default_nettype none

module wrms_sub #(
  parameter int W = 8
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] diff,
  output logic              ge
);

  logic [W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[W-1:0];
  // no borrow out means a >= b
  assign ge   = ~wide[W];

endmodule

`default_nettype wire

@@ hw/rtl/windowed_rms.sv @@
// windowed_rms: rms over a window of samples. a sample that does not close the window goes
// through accept (ST_IDLE) and accumulate (ST_ACCUM). the closing sample then goes through
// a restoring divide, one quotient bit per cycle, then a square root, one root bit per
// cycle, both through the one shared subtract unit, before out_valid. in_ready stays low.
// reset (sync, active low) clears sum, count and output valid, and sets window length to 32.
// depends on wrms_pkg and wrms_sub
`default_nettype none

module windowed_rms #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [wrms_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [wrms_pkg::IN_W-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [wrms_pkg::RMS_W-1:0]    out_rms
);

  localparam int SB     = SAMPLE_BITS;
  localparam int SQ_W   = 2 * SB;
  localparam int SUM_W  = 2 * SB - 1 + $clog2(MAX_WINDOW);
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int WORK_W = 2 * ROOT_W;
  localparam int UNIT_W = (ROOT_W + 2 > wrms_pkg::CFG_W + 1) ? ROOT_W + 2
                                                              : wrms_pkg::CFG_W + 1;
  localparam int STEP_W = $clog2(SUM_W);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);

  wrms_pkg::wrms_state_t state_r, state_nxt;

  logic [wrms_pkg::CFG_W-1:0] wlen_r;
  logic [wrms_pkg::CFG_W-1:0] len_eff;
  logic [wrms_pkg::CFG_W-1:0] len_r, len_nxt;
  logic [SQ_W-1:0]            sq_r, sq_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt, sum_add;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt, cnt_plus;
  logic [WORK_W-1:0]          work_r, work_nxt;
  logic [UNIT_W-1:0]          rem_r, rem_nxt;
  logic [ROOT_W-1:0]          root_r, root_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [wrms_pkg::RMS_W-1:0] out_rms_r, out_rms_nxt;

  logic [SB-1:0]     raw;
  logic [SB-1:0]     mag;
  logic [UNIT_W-1:0] unit_a, unit_b, unit_diff;
  logic              unit_ge;

  wrms_sub #(
    .W (UNIT_W)
  ) u_sub (
    .a    (unit_a),
    .b    (unit_b),
    .diff (unit_diff),
    .ge   (unit_ge)
  );

  // low SAMPLE_BITS bits of the port, sign bit at the top of that field
  assign raw = SB'($unsigned(in_sample));
  assign mag = raw[SB-1] ? (~raw + 1'b1) : raw;

  always_comb begin
    if (wlen_r == '0) begin
      len_eff = wrms_pkg::CFG_W'(1);
    end else if (32'(wlen_r) > MAX_WINDOW) begin
      len_eff = wrms_pkg::CFG_W'(MAX_WINDOW);
    end else begin
      len_eff = wlen_r;
    end
  end

  assign sum_add  = sum_r + SUM_W'(sq_r);
  assign cnt_plus = cnt_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    sq_nxt        = sq_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_rms_nxt   = out_rms_r;
    unit_a        = '0;
    unit_b        = '0;
    in_ready      = 1'b0;

    case (state_r)
      wrms_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sq_nxt    = SQ_W'(mag) * SQ_W'(mag);
          state_nxt = wrms_pkg::ST_ACCUM;
        end
      end

      wrms_pkg::ST_ACCUM: begin
        if (32'(cnt_plus) >= 32'(len_eff)) begin
          work_nxt  = WORK_W'(sum_add);
          sum_nxt   = '0;
          cnt_nxt   = '0;
          len_nxt   = len_eff;
          rem_nxt   = '0;
          step_nxt  = STEP_W'(SUM_W - 1);
          state_nxt = wrms_pkg::ST_DIV;
        end else begin
          sum_nxt   = sum_add;
          cnt_nxt   = cnt_plus;
          state_nxt = wrms_pkg::ST_IDLE;
        end
      end

      wrms_pkg::ST_DIV: begin
        // restoring divide: dividend bits leave at the top, quotient bits enter at the bottom
        unit_a = {rem_r[UNIT_W-2:0], work_r[SUM_W-1]};
        unit_b = UNIT_W'(len_r);
        rem_nxt = unit_ge ? unit_diff : unit_a;
        work_nxt[SUM_W-1:0] = {work_r[SUM_W-2:0], unit_ge};
        if (step_r == '0) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = STEP_W'(ROOT_W - 1);
          state_nxt = wrms_pkg::ST_SQRT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end

      wrms_pkg::ST_SQRT: begin
        // one root bit per step: bring down two bits, try (root << 2) | 1
        unit_a   = {rem_r[UNIT_W-3:0], work_r[WORK_W-1 -: 2]};
        unit_b   = UNIT_W'({root_r[ROOT_W-2:0], 2'b01});
        rem_nxt  = unit_ge ? unit_diff : unit_a;
        root_nxt = {root_r[ROOT_W-2:0], unit_ge};
        work_nxt = work_r << 2;
        if (step_r == '0) begin
          state_nxt = wrms_pkg::ST_OUT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end

      wrms_pkg::ST_OUT: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (64'(root_r) > 64'(wrms_pkg::RMS_MAX)) begin
            out_rms_nxt = wrms_pkg::RMS_MAX;
          end else begin
            out_rms_nxt = wrms_pkg::RMS_W'(root_r);
          end
          state_nxt = wrms_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = wrms_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrms_pkg::ST_IDLE;
      wlen_r      <= wrms_pkg::CFG_W'(wrms_pkg::WINDOW_RESET);
      sum_r       <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        wlen_r <= cfg_wr_data;
      end
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r     <= len_nxt;
    sq_r      <= sq_nxt;
    work_r    <= work_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    out_rms_r <= out_rms_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rms   = out_rms_r;

endmodule

`default_nettype wire

@@ tb/windowed_rms_tb.sv @@
// windowed_rms_tb: self-checking testbench for the windowed rms block
// random and directed samples, window length changes, result check against a local model
// depends on wrms_pkg and the windowed_rms rtl
`timescale 1ns / 1ps

class rms_scoreboard;
  localparam int WINDOW_CAP = 1024;

  logic [wrms_pkg::CFG_W-1:0] window_reg;
  logic [40:0]                square_sum;
  logic [wrms_pkg::CFG_W-1:0] samples_seen;
  logic [wrms_pkg::RMS_W-1:0] expected_rms[$];
  int                         errors;
  int                         samples_noted;
  int                         results_checked;

  function new();
    window_reg      = wrms_pkg::CFG_W'(wrms_pkg::WINDOW_RESET);
    square_sum      = '0;
    samples_seen    = '0;
    errors          = 0;
    samples_noted   = 0;
    results_checked = 0;
  endfunction

  function void set_window(logic [wrms_pkg::CFG_W-1:0] value);
    window_reg = value;
  endfunction

  function int pending();
    return expected_rms.size();
  endfunction

  // largest r with r*r <= x, built one bit at a time from the top
  function logic [31:0] root_floor(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root[31:0];
  endfunction

  function void note_sample(logic signed [wrms_pkg::IN_W-1:0] s);
    longint      mag;
    longint      len;
    logic [31:0] root;
    mag = s;
    if (mag < 0) mag = -mag;
    square_sum   = square_sum + 41'(mag * mag);
    samples_seen = samples_seen + 1'b1;
    samples_noted++;
    len = window_reg;
    if (len == 0) len = 1;
    if (len > WINDOW_CAP) len = WINDOW_CAP;
    // a shortened window closes on the next sample when the count is already at or past it
    if (samples_seen >= len) begin
      root = root_floor(64'(square_sum) / 64'(len));
      if (root > 32'(wrms_pkg::RMS_MAX)) root = 32'(wrms_pkg::RMS_MAX);
      expected_rms.push_back(root[wrms_pkg::RMS_W-1:0]);
      square_sum   = '0;
      samples_seen = '0;
    end
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task check_rms(logic [wrms_pkg::RMS_W-1:0] got);
    logic [wrms_pkg::RMS_W-1:0] want;
    if (expected_rms.size() == 0) begin
      report_mismatch($sformatf("rms word %0d with nothing expected", got));
    end else begin
      want = expected_rms.pop_front();
      results_checked++;
      if (got !== want)
        report_mismatch($sformatf("rms got %0d expected %0d", got, want));
    end
  endtask

  task check_leftovers();
    if (expected_rms.size() != 0)
      report_mismatch($sformatf("%0d rms words never came", expected_rms.size()));
  endtask
endclass

module windowed_rms_tb;

  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 400000;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_wr_en = 1'b0;
  logic [wrms_pkg::CFG_W-1:0]        cfg_wr_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic signed [wrms_pkg::IN_W-1:0]  in_sample = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [wrms_pkg::RMS_W-1:0]        out_rms;

  rms_scoreboard sb = new();
  bit  calm = 1'b0;        // no idling on either side
  bit  idle_on = 1'b1;     // idling allowed in the current phase
  int  stall_left = 0;
  int  cycles = 0;
  int  settings_used = 0;

  windowed_rms u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_rms    (out_rms)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rms words pending", cycles, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver side: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_rms(out_rms);
  end

  task send_sample(input logic signed [wrms_pkg::IN_W-1:0] s);
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
    if (!calm && idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // stop sending, let every rms word arrive and the block go quiet
  task drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_window(input logic [wrms_pkg::CFG_W-1:0] len);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    sb.set_window(len);
    cfg_wr_en <= 1'b0;
    settings_used++;
    idle_on = ($urandom_range(0, 3) != 0);
  endtask

  function logic signed [wrms_pkg::IN_W-1:0] pick_sample();
    logic signed [wrms_pkg::IN_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh8000;
          1: v = 16'sh7fff;
          2: v = 16'sh0000;
          3: v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
      1, 2: begin
        v = wrms_pkg::IN_W'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = wrms_pkg::IN_W'($urandom);
    endcase
    return v;
  endfunction

  task send_random(input int count);
    for (int i = 0; i < count; i++) send_sample(pick_sample());
  endtask

  logic [wrms_pkg::CFG_W-1:0] phase_len;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // window length straight out of reset
    send_random(64);

    // zero length acts as one: every sample gives its magnitude
    write_window('0);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sh5555);
    send_sample(-16'sh5556);

    write_window(wrms_pkg::CFG_W'(2));
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(-16'sh7fff);

    // shorter window while four samples are already counted
    write_window(wrms_pkg::CFG_W'(5));
    send_sample(16'sd1000);
    send_sample(-16'sd2000);
    send_sample(16'sd3);
    send_sample(16'sh8000);
    write_window(wrms_pkg::CFG_W'(2));
    send_sample(16'sd7);

    // above the cap, then cut short after a partial window
    write_window('1);
    send_random(20);
    write_window(wrms_pkg::CFG_W'(9));
    send_random(18);

    // 1024 samples at the capped window length, mostly the most negative code
    write_window(wrms_pkg::CFG_W'(1025));
    for (int i = 0; i < 1024; i++)
      send_sample(($urandom_range(0, 7) != 0) ? 16'sh8000 : pick_sample());

    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 5))
        0: phase_len = '0;
        1: phase_len = wrms_pkg::CFG_W'(1);
        2: phase_len = wrms_pkg::CFG_W'(2);
        3: phase_len = wrms_pkg::CFG_W'(3);
        default: phase_len = wrms_pkg::CFG_W'($urandom_range(4, 24));
      endcase
      write_window(phase_len);
      send_random($urandom_range(10, 20));
    end

    write_window(wrms_pkg::CFG_W'(4));
    calm = 1'b1;
    send_random(40);

    drain();
    sb.check_leftovers();
    $display("covered %0d samples over %0d window settings, %0d rms words checked",
             sb.samples_noted, settings_used, sb.results_checked);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
